// File: rtl/segregated_fit_pool_allocator_defines.svh
// Assertion macros shared by the allocator's checker.
// No dependencies; each macro expects clk and rst in scope.
`ifndef SEGREGATED_FIT_POOL_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_FIT_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SFPA_ASSERT_IMM(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfpa_pkg.sv
// Shared constants for the segregated-fit pool allocator.
// No dependencies; imported by the allocator modules and its checker.
`timescale 1ns / 1ps

package sfpa_pkg;

  // Byte offsets inside the pool, wide enough for the 64 KiB end offset.
  localparam int OFF_W = 17;

  localparam logic [OFF_W-1:0] NIL_LINK  = 17'h1FFFF;
  localparam logic [31:0]      NIL_WORD  = 32'h0001FFFF;
  localparam logic [OFF_W-1:0] HDR_BYTES = 17'd8;
  localparam logic [OFF_W-1:0] MIN_BLOCK = 17'd24;
  localparam logic [OFF_W-1:0] FMT_MIN   = 17'd32;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_RESIZE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_REJECT   = 2'd2;
  localparam logic [1:0] STATUS_FREED    = 2'd3;

endpackage

// File: rtl/sfpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sfpa_bin_index.sv
// Maps a block size to its two-level bin: octave, then linear slice of it.
// Depends on sfpa_pkg.
`timescale 1ns / 1ps

module sfpa_bin_index #(
  parameter int FIRST_LEVELS  = 24,
  parameter int SECOND_LEVELS = 4
) (
  input  logic [sfpa_pkg::OFF_W-1:0]                     size,
  output logic [$clog2(FIRST_LEVELS*SECOND_LEVELS)-1:0] bin
);
  import sfpa_pkg::*;

  localparam int BW  = $clog2(FIRST_LEVELS * SECOND_LEVELS);
  localparam int FLW = $clog2(FIRST_LEVELS);

  // Slice boundary j of octave f, evaluated at elaboration only.
  function automatic logic [39:0] thr(input int f, input int j);
    logic [39:0] step;
    step = (40'd1 << f) / SECOND_LEVELS;
    if (step == 40'd0) step = 40'd1;
    return 40'(j) * step;
  endfunction

  logic [39:0] thr_tab [FIRST_LEVELS][SECOND_LEVELS];

  for (genvar f = 0; f < FIRST_LEVELS; f++) begin : g_fl
    for (genvar j = 0; j < SECOND_LEVELS; j++) begin : g_sl
      assign thr_tab[f][j] = thr(f, j);
    end
  end

  logic [4:0]     fl;
  logic [FLW-1:0] flc;
  logic [17:0]    base;
  logic [17:0]    diff;
  logic [4:0]     sl;

  always_comb begin
    fl = 5'd0;
    for (int i = 1; i < OFF_W; i++) begin
      if (size[i]) fl = 5'(i);
    end
    if (fl >= 5'(FIRST_LEVELS - 1)) flc = FLW'(FIRST_LEVELS - 1);
    else flc = fl[FLW-1:0];
    base = 18'd1 << flc;
    diff = ({1'b0, size} > base) ? ({1'b0, size} - base) : 18'd0;
    sl = 5'd0;
    for (int j = 1; j < SECOND_LEVELS; j++) begin
      if ({22'd0, diff} >= thr_tab[flc][j]) sl = sl + 5'd1;
    end
    bin = BW'(int'(flc) * SECOND_LEVELS + int'(sl));
  end

endmodule

// File: rtl/segregated_fit_pool_allocator.sv
// Two-level segregated-fit allocator; one request per start beat, one result beat per request.
// Free walks the block chain to validate the pointer, and a moving resize adds an allocate.
// Throughput: at most one pool access per cycle, one request at a time.
// Reset (synchronous) and any pool_bytes write reformat the pool, busy high.
// Results are presented for one cycle on done; the receiver cannot stall them.
`timescale 1ns / 1ps

module segregated_fit_pool_allocator #(
  parameter int POOL_BYTES    = 65536,
  parameter int FIRST_LEVELS  = 24,
  parameter int SECOND_LEVELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] request_size,
  input  logic [15:0] block_address,
  output logic        done,
  output logic [15:0] result_address,
  output logic [1:0]  status,
  output logic [16:0] copy_bytes,
  input  logic        pool_bytes_we,
  input  logic [16:0] pool_bytes
);
  import sfpa_pkg::*;

  // The pool never spans more than the 64 KiB addressable by block_address.
  localparam int SPAN_BYTES = (POOL_BYTES < 65536) ? POOL_BYTES : 65536;
  localparam int DEPTH      = SPAN_BYTES / 4;
  localparam int AW         = $clog2(DEPTH);
  localparam int BINS       = FIRST_LEVELS * SECOND_LEVELS;
  localparam int BW         = $clog2(BINS);
  localparam int KW         = $clog2(BINS + 1);

  localparam logic [OFF_W-1:0] SPAN_OFF = OFF_W'(SPAN_BYTES);

  // Sequencer states. Unlink and link are shared subroutines that return through ret.
  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_EMIT = 6'd1;
  localparam logic [5:0] ST_FMT0 = 6'd2;
  localparam logic [5:0] ST_FMT1 = 6'd3;
  localparam logic [5:0] ST_FMT2 = 6'd4;
  localparam logic [5:0] ST_FMT3 = 6'd5;
  localparam logic [5:0] ST_VU0  = 6'd6;
  localparam logic [5:0] ST_VU1  = 6'd7;
  localparam logic [5:0] ST_VU2  = 6'd8;
  localparam logic [5:0] ST_VU3  = 6'd9;
  localparam logic [5:0] ST_VU4  = 6'd10;
  localparam logic [5:0] ST_AL0  = 6'd11;
  localparam logic [5:0] ST_AL1  = 6'd12;
  localparam logic [5:0] ST_AL2  = 6'd13;
  localparam logic [5:0] ST_AL3  = 6'd14;
  localparam logic [5:0] ST_AL4  = 6'd15;
  localparam logic [5:0] ST_AL5  = 6'd16;
  localparam logic [5:0] ST_AL6  = 6'd17;
  localparam logic [5:0] ST_AL7  = 6'd18;
  localparam logic [5:0] ST_AL8  = 6'd19;
  localparam logic [5:0] ST_AL9  = 6'd20;
  localparam logic [5:0] ST_AL10 = 6'd21;
  localparam logic [5:0] ST_AL11 = 6'd22;
  localparam logic [5:0] ST_RL0  = 6'd23;
  localparam logic [5:0] ST_RL1  = 6'd24;
  localparam logic [5:0] ST_RL2  = 6'd25;
  localparam logic [5:0] ST_RL3  = 6'd26;
  localparam logic [5:0] ST_RL4  = 6'd27;
  localparam logic [5:0] ST_RL5  = 6'd28;
  localparam logic [5:0] ST_RL6  = 6'd29;
  localparam logic [5:0] ST_RL7  = 6'd30;
  localparam logic [5:0] ST_RL8  = 6'd31;
  localparam logic [5:0] ST_RL9  = 6'd32;
  localparam logic [5:0] ST_RL10 = 6'd33;
  localparam logic [5:0] ST_RL11 = 6'd34;
  localparam logic [5:0] ST_UL0  = 6'd35;
  localparam logic [5:0] ST_UL1  = 6'd36;
  localparam logic [5:0] ST_UL2  = 6'd37;
  localparam logic [5:0] ST_UL3  = 6'd38;
  localparam logic [5:0] ST_UL4  = 6'd39;
  localparam logic [5:0] ST_UL5  = 6'd40;
  localparam logic [5:0] ST_UL6  = 6'd41;
  localparam logic [5:0] ST_LK0  = 6'd42;
  localparam logic [5:0] ST_LK1  = 6'd43;
  localparam logic [5:0] ST_LK2  = 6'd44;
  localparam logic [5:0] ST_LK3  = 6'd45;
  localparam logic [5:0] ST_LK4  = 6'd46;

  function automatic logic [AW-1:0] widx(input logic [OFF_W-1:0] off);
    return off[AW+1:2];
  endfunction

  // Control and configuration state.
  logic [5:0]       state;
  logic [5:0]       ret;
  logic [OFF_W-1:0] pool_cfg;
  logic             ready;
  logic [OFF_W-1:0] limit;
  logic [OFF_W-1:0] fend;
  logic [BINS-1:0]  bin_vld;

  // Request and working registers.
  logic [1:0]       cmd;
  logic [31:0]      req;
  logic [15:0]      ptr;
  logic [OFF_W-1:0] vb;
  logic [OFF_W-1:0] c;
  logic [OFF_W-1:0] old;
  logic             moving;
  logic [OFF_W-1:0] rb, rs, pb;
  logic [OFF_W-1:0] ub, usz, un, up;
  logic [OFF_W-1:0] lb, lsz, ln;
  logic [BW-1:0]    bin_sel;
  logic [KW-1:0]    k;
  logic [OFF_W-1:0] cur, needed, fb, fsz;
  logic [15:0]      pend_addr;
  logic [1:0]       pend_status;
  logic [OFF_W-1:0] pend_copy;

  // Memory ports.
  logic             p_we;
  logic [OFF_W-1:0] p_woff, p_roff;
  logic [31:0]      p_wdata, p_rdata;
  logic             b_we;
  logic [BW-1:0]    b_waddr, b_raddr;
  logic [OFF_W-1:0] b_wdata, b_rdata;

  // Derived values.
  logic [OFF_W-1:0] sz_rd;
  logic [17:0]      walk_sum;
  logic [32:0]      need_sum, need_al, need33;
  logic [OFF_W-1:0] bin_in;
  logic [BW-1:0]    bin_out;
  logic [OFF_W-1:0] total, avail;
  logic [OFF_W-1:0] rem, sp;
  logic [OFF_W-1:0] head_k, head_sel;

  // The pool memory holds headers, prev-size words and free-list links in band.
  sfpa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pool (
    .clk   (clk),
    .we    (p_we),
    .waddr (widx(p_woff)),
    .wdata (p_wdata),
    .raddr (widx(p_roff)),
    .rdata (p_rdata)
  );

  // Free-list heads; a head whose valid bit is clear reads as the empty link.
  sfpa_ram #(.WIDTH(OFF_W), .DEPTH(BINS)) u_bins (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  sfpa_bin_index #(
    .FIRST_LEVELS  (FIRST_LEVELS),
    .SECOND_LEVELS (SECOND_LEVELS)
  ) u_bin_index (
    .size (bin_in),
    .bin  (bin_out)
  );

  assign sz_rd    = {p_rdata[16:3], 3'b000};
  assign walk_sum = {1'b0, c} + {1'b0, sz_rd};

  // Request plus header, rounded up to the 8-byte grain, never below the minimum block.
  assign need_sum = {1'b0, req} + 33'd15;
  assign need_al  = {need_sum[32:3], 3'b000};
  assign need33   = (need_al < 33'd24) ? 33'd24 : need_al;

  assign total = (pool_cfg > SPAN_OFF) ? SPAN_OFF : pool_cfg;
  assign avail = {total[16:3], 3'b000};

  assign rem = fsz - needed;
  assign sp  = fb + needed;

  assign head_k   = bin_vld[k[BW-1:0]] ? b_rdata : NIL_LINK;
  assign head_sel = bin_vld[bin_sel] ? b_rdata : NIL_LINK;

  // The shared bin mapper serves unlink, link and the start of the fit search.
  assign bin_in = (state == ST_UL0) ? usz :
                  (state == ST_LK0) ? lsz : need33[OFF_W-1:0];

  // A configuration write in this cycle restarts formatting, so no beat is taken with it.
  assign busy = (state != ST_IDLE) || pool_bytes_we;

  // Memory port control: at most one pool access per state.
  always_comb begin
    p_we    = 1'b0;
    p_woff  = '0;
    p_wdata = '0;
    p_roff  = '0;
    b_we    = 1'b0;
    b_waddr = bin_sel;
    b_wdata = '0;
    b_raddr = bin_out;
    unique case (state)
      ST_FMT0: begin
        p_we    = (total > FMT_MIN);
        p_woff  = '0;
        p_wdata = {15'd0, avail - HDR_BYTES};
      end
      ST_FMT1: begin
        p_we   = 1'b1;
        p_woff = 17'd4;
      end
      ST_FMT2: begin
        p_we    = 1'b1;
        p_woff  = fend - HDR_BYTES;
        p_wdata = 32'd1;
      end
      ST_FMT3: begin
        p_we    = 1'b1;
        p_woff  = fend - 17'd4;
        p_wdata = {15'd0, fend - HDR_BYTES};
      end
      ST_VU1: p_roff = c;
      ST_VU3: p_roff = vb;
      ST_AL1: b_raddr = k[BW-1:0];
      ST_AL3: p_roff = cur;
      ST_AL4: p_roff = cur + HDR_BYTES;
      ST_AL6: begin
        p_we = 1'b1;
        if (rem >= MIN_BLOCK) begin
          p_woff  = sp;
          p_wdata = {15'd0, rem};
        end else begin
          p_woff  = fb;
          p_wdata = {15'd0, fsz} | 32'd1;
        end
      end
      ST_AL7: begin
        p_we    = 1'b1;
        p_woff  = sp + 17'd4;
        p_wdata = {15'd0, needed};
      end
      ST_AL8: begin
        p_we    = 1'b1;
        p_woff  = fb;
        p_wdata = {15'd0, needed} | 32'd1;
      end
      ST_AL9: begin
        p_we    = 1'b1;
        p_woff  = sp + rem + 17'd4;
        p_wdata = {15'd0, rem};
      end
      ST_AL10: begin
        p_we    = 1'b1;
        p_woff  = fb + fsz + 17'd4;
        p_wdata = {15'd0, fsz};
      end
      ST_RL0: p_roff = rb;
      ST_RL1: begin
        p_we    = 1'b1;
        p_woff  = rb;
        p_wdata = {15'd0, sz_rd};
      end
      ST_RL2: p_roff = rb + rs;
      ST_RL4: begin
        p_we    = 1'b1;
        p_woff  = rb;
        p_wdata = {15'd0, rs + usz};
      end
      ST_RL5: begin
        p_we    = 1'b1;
        p_woff  = rb + rs + 17'd4;
        p_wdata = {15'd0, rs};
      end
      ST_RL6: p_roff = rb + 17'd4;
      ST_RL8: p_roff = pb;
      ST_RL10: begin
        p_we    = 1'b1;
        p_woff  = pb;
        p_wdata = {15'd0, rs + usz};
      end
      ST_RL11: begin
        p_we    = 1'b1;
        p_woff  = rb + rs + 17'd4;
        p_wdata = {15'd0, rs};
      end
      ST_UL0: p_roff = ub + HDR_BYTES;
      ST_UL1: p_roff = ub + 17'd12;
      ST_UL3: begin
        if (up != NIL_LINK) begin
          p_we    = 1'b1;
          p_woff  = up + HDR_BYTES;
          p_wdata = {15'd0, un};
        end else begin
          b_we    = 1'b1;
          b_wdata = un;
        end
      end
      ST_UL4: begin
        p_we    = (un != NIL_LINK);
        p_woff  = un + 17'd12;
        p_wdata = {15'd0, up};
      end
      ST_UL5: begin
        p_we    = 1'b1;
        p_woff  = ub + HDR_BYTES;
        p_wdata = NIL_WORD;
      end
      ST_UL6: begin
        p_we    = 1'b1;
        p_woff  = ub + 17'd12;
        p_wdata = NIL_WORD;
      end
      ST_LK1: begin
        p_we    = 1'b1;
        p_woff  = lb + 17'd12;
        p_wdata = NIL_WORD;
      end
      ST_LK2: begin
        // The head read back in LK1 is held in ln; the bin port has moved on since.
        p_we    = 1'b1;
        p_woff  = lb + HDR_BYTES;
        p_wdata = {15'd0, ln};
      end
      ST_LK3: begin
        p_we    = (ln != NIL_LINK);
        p_woff  = ln + 17'd12;
        p_wdata = {15'd0, lb};
      end
      ST_LK4: begin
        b_we    = 1'b1;
        b_wdata = lb;
      end
      default: begin
      end
    endcase
  end

  // Sequencer. Every request path ends in the emit state, which drives one result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FMT0;
      pool_cfg <= 17'h10000;
      ready    <= 1'b0;
      limit    <= '0;
      bin_vld  <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd         <= command;
            req         <= request_size;
            ptr         <= block_address;
            vb          <= {1'b0, block_address} - HDR_BYTES;
            moving      <= 1'b0;
            pend_addr   <= '0;
            pend_status <= STATUS_REJECT;
            pend_copy   <= '0;
            unique case (command)
              CMD_ALLOC: state <= ST_AL0;
              CMD_FREE:  state <= (block_address >= 16'd8) ? ST_VU0 : ST_EMIT;
              CMD_RESIZE: begin
                if (block_address == 16'd0) state <= ST_AL0;
                else if (block_address >= 16'd8) state <= ST_VU0;
                else state <= ST_EMIT;
              end
              default: state <= ST_EMIT;
            endcase
          end
        end
        ST_EMIT: begin
          result_address <= pend_addr;
          status         <= pend_status;
          copy_bytes     <= pend_copy;
          done           <= 1'b1;
          state          <= ST_IDLE;
        end

        // Formatting: a pool over 32 bytes gets one free block and a used zero-size sentinel.
        ST_FMT0: begin
          bin_vld <= '0;
          ready   <= 1'b0;
          limit   <= '0;
          fend    <= avail;
          state   <= (total > FMT_MIN) ? ST_FMT1 : ST_IDLE;
        end
        ST_FMT1: state <= ST_FMT2;
        ST_FMT2: state <= ST_FMT3;
        ST_FMT3: begin
          limit <= fend;
          ready <= 1'b1;
          lb    <= '0;
          lsz   <= fend - HDR_BYTES;
          ret   <= ST_IDLE;
          state <= ST_LK0;
        end

        // Pointer check: walk the block chain from offset zero up to the candidate header.
        ST_VU0: begin
          c <= '0;
          if (!ready || vb >= limit) state <= ST_EMIT;
          else if (vb == '0) state <= ST_VU3;
          else state <= ST_VU1;
        end
        ST_VU1: state <= ST_VU2;
        ST_VU2: begin
          if (sz_rd == '0) begin
            state <= ST_EMIT;
          end else if (walk_sum < {1'b0, vb}) begin
            c     <= walk_sum[OFF_W-1:0];
            state <= ST_VU1;
          end else if (walk_sum == {1'b0, vb}) begin
            state <= ST_VU3;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_VU3: state <= ST_VU4;
        ST_VU4: begin
          if (sz_rd != '0 && p_rdata[0]) begin
            old <= sz_rd - HDR_BYTES;
            rb  <= vb;
            if (cmd == CMD_FREE) begin
              pend_status <= STATUS_OK;
              state       <= ST_RL0;
            end else if (req == 32'd0) begin
              pend_status <= STATUS_FREED;
              state       <= ST_RL0;
            end else if (req <= {15'd0, sz_rd - HDR_BYTES}) begin
              pend_addr   <= ptr;
              pend_status <= STATUS_OK;
              state       <= ST_EMIT;
            end else begin
              moving <= 1'b1;
              state  <= ST_AL0;
            end
          end else begin
            state <= ST_EMIT;
          end
        end

        // Allocate: first fit, scanning bins upward from the one the rounded size maps to.
        ST_AL0: begin
          pend_addr <= '0;
          pend_copy <= '0;
          if (req == 32'd0) begin
            pend_status <= STATUS_REJECT;
            state       <= ST_EMIT;
          end else if (!ready || need33 > {16'd0, limit}) begin
            pend_status <= STATUS_NO_SPACE;
            state       <= ST_EMIT;
          end else begin
            needed <= need33[OFF_W-1:0];
            k      <= KW'(bin_out);
            state  <= ST_AL1;
          end
        end
        ST_AL1: begin
          if (k >= KW'(BINS)) begin
            pend_status <= STATUS_NO_SPACE;
            state       <= ST_EMIT;
          end else begin
            state <= ST_AL2;
          end
        end
        ST_AL2: begin
          if (head_k == NIL_LINK) begin
            k     <= k + 1'b1;
            state <= ST_AL1;
          end else begin
            cur   <= head_k;
            state <= ST_AL3;
          end
        end
        ST_AL3: state <= ST_AL4;
        ST_AL4: begin
          if (sz_rd >= needed) begin
            fb    <= cur;
            fsz   <= sz_rd;
            ub    <= cur;
            usz   <= sz_rd;
            ret   <= ST_AL6;
            state <= ST_UL0;
          end else begin
            state <= ST_AL5;
          end
        end
        ST_AL5: begin
          if (p_rdata[16:0] == NIL_LINK) begin
            k     <= k + 1'b1;
            state <= ST_AL1;
          end else begin
            cur   <= p_rdata[16:0];
            state <= ST_AL3;
          end
        end
        ST_AL6:  state <= (rem >= MIN_BLOCK) ? ST_AL7 : ST_AL10;
        ST_AL7:  state <= ST_AL8;
        ST_AL8:  state <= ST_AL9;
        ST_AL9: begin
          lb    <= sp;
          lsz   <= rem;
          ret   <= ST_AL11;
          state <= ST_LK0;
        end
        ST_AL10: state <= ST_AL11;
        ST_AL11: begin
          pend_addr   <= fb[15:0] + 16'd8;
          pend_status <= STATUS_OK;
          if (moving) begin
            // The old block goes back only once the new one is granted.
            pend_copy <= old;
            rb        <= vb;
            state     <= ST_RL0;
          end else begin
            state <= ST_EMIT;
          end
        end

        // Release: clear the used bit, merge the following block, then the preceding one.
        ST_RL0: state <= ST_RL1;
        ST_RL1: begin
          rs    <= sz_rd;
          state <= ST_RL2;
        end
        ST_RL2: state <= ST_RL3;
        ST_RL3: begin
          if (sz_rd != '0 && !p_rdata[0]) begin
            ub    <= rb + rs;
            usz   <= sz_rd;
            ret   <= ST_RL4;
            state <= ST_UL0;
          end else begin
            state <= ST_RL6;
          end
        end
        ST_RL4: begin
          rs    <= rs + usz;
          state <= ST_RL5;
        end
        ST_RL5: state <= ST_RL6;
        ST_RL6: state <= ST_RL7;
        ST_RL7: begin
          if (p_rdata != 32'd0 && p_rdata <= {15'd0, rb}) begin
            pb    <= rb - p_rdata[OFF_W-1:0];
            state <= ST_RL8;
          end else begin
            lb    <= rb;
            lsz   <= rs;
            ret   <= ST_EMIT;
            state <= ST_LK0;
          end
        end
        ST_RL8: state <= ST_RL9;
        ST_RL9: begin
          if (!p_rdata[0]) begin
            ub    <= pb;
            usz   <= sz_rd;
            ret   <= ST_RL10;
            state <= ST_UL0;
          end else begin
            lb    <= rb;
            lsz   <= rs;
            ret   <= ST_EMIT;
            state <= ST_LK0;
          end
        end
        ST_RL10: begin
          rs    <= rs + usz;
          rb    <= pb;
          state <= ST_RL11;
        end
        ST_RL11: begin
          lb    <= rb;
          lsz   <= rs;
          ret   <= ST_EMIT;
          state <= ST_LK0;
        end

        // Unlink ub (size usz) from its free list.
        ST_UL0: begin
          bin_sel <= bin_out;
          state   <= ST_UL1;
        end
        ST_UL1: begin
          un    <= p_rdata[16:0];
          state <= ST_UL2;
        end
        ST_UL2: begin
          up    <= p_rdata[16:0];
          state <= ST_UL3;
        end
        ST_UL3: begin
          if (up == NIL_LINK) bin_vld[bin_sel] <= 1'b1;
          state <= ST_UL4;
        end
        ST_UL4: state <= ST_UL5;
        ST_UL5: state <= ST_UL6;
        ST_UL6: state <= ret;

        // Link lb (size lsz) at the head of its free list.
        ST_LK0: begin
          bin_sel <= bin_out;
          state   <= ST_LK1;
        end
        ST_LK1: begin
          ln    <= head_sel;
          state <= ST_LK2;
        end
        ST_LK2: state <= ST_LK3;
        ST_LK3: state <= ST_LK4;
        ST_LK4: begin
          bin_vld[bin_sel] <= 1'b1;
          state            <= ret;
        end
        default: state <= ST_IDLE;
      endcase

      if (pool_bytes_we) begin
        pool_cfg <= pool_bytes;
        state    <= ST_FMT0;
      end
    end
  end

endmodule

// File: rtl/sfpa_checker.sv
// Port-level checks on the allocator's request and result beats, bound to the top level.
// Depends on sfpa_pkg and segregated_fit_pool_allocator_defines.svh.
`timescale 1ns / 1ps
`include "segregated_fit_pool_allocator_defines.svh"

module sfpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] result_address,
  input logic [1:0]  status,
  input logic [16:0] copy_bytes,
  input logic        pool_bytes_we
);
  import sfpa_pkg::*;

  // A copy length only comes with a granted moving resize.
  `SFPA_ASSERT_IMM(a_copy_ok, done && copy_bytes != 17'd0, status == STATUS_OK && result_address != 16'd0, "copy length without a granted address")

  // Failed or freeing requests never report an address.
  `SFPA_ASSERT_IMM(a_fail_null, done && status != STATUS_OK, result_address == 16'd0, "address reported on a failed request")

  // Payload offsets sit on the 8-byte grain.
  `SFPA_ASSERT_IMM(a_align, done, result_address[2:0] == 3'd0, "misaligned payload address")

  // An accepted request keeps the block busy until its result beat.
  `SFPA_ASSERT_NXT(a_accept, start && !busy, busy || done, "accepted request dropped")

  // No request beat is taken in a cycle that writes the pool size.
  `SFPA_ASSERT_IMM(a_cfg_busy, pool_bytes_we, busy, "request accepted with a pool size write")

endmodule

bind segregated_fit_pool_allocator sfpa_checker u_sfpa_checker (.*);

// File: sim/segregated_fit_pool_allocator_test.sv
// Self-checking testbench for the segregated-fit pool allocator.
// Depends on rtl/sfpa_pkg.sv and rtl/segregated_fit_pool_allocator.sv; the
// expected results come from an in-bench model of the pool and its free bins.
`timescale 1ns / 1ps

module segregated_fit_pool_allocator_test;
  import sfpa_pkg::*;

  localparam int unsigned NONE      = 32'h1FFFF;
  localparam int unsigned MEM_WORDS = 16384;
  localparam int unsigned BINS      = 96;
  localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  stat;
    logic [16:0] copy;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [31:0] request_size;
  logic [15:0] block_address;
  logic        done;
  logic [15:0] result_address;
  logic [1:0]  status;
  logic [16:0] copy_bytes;
  logic        pool_bytes_we;
  logic [16:0] pool_bytes;

  segregated_fit_pool_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .request_size(request_size), .block_address(block_address),
    .done(done), .result_address(result_address), .status(status),
    .copy_bytes(copy_bytes), .pool_bytes_we(pool_bytes_we), .pool_bytes(pool_bytes)
  );

  // Mirror of the allocator: pool words, bin heads, formatted flag and end offset.
  logic [31:0] pool_mem [MEM_WORDS];
  int unsigned free_heads [BINS];
  bit          pool_up;
  int unsigned pool_end;
  int unsigned pool_size_reg;

  outcome_t    pending_results[$];
  logic [15:0] live_blocks[$];
  int          mismatches;
  longint unsigned cycles;
  bit          no_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pool model. Offsets are bytes; a block header holds the size with the used
  // flag in bit 0, then the previous block size, then next/prev free links.
  // ---------------------------------------------------------------------------
  function automatic int unsigned mem_rd(int unsigned off);
    return ((off >> 2) < MEM_WORDS) ? pool_mem[off >> 2] : 0;
  endfunction

  function automatic void mem_wr(int unsigned off, int unsigned v);
    if ((off >> 2) < MEM_WORDS) pool_mem[off >> 2] = v;
  endfunction

  function automatic int unsigned size_at(int unsigned b);
    return mem_rd(b) & ~32'd7;
  endfunction

  function automatic bit used_at(int unsigned b);
    return (mem_rd(b) & 1) != 0;
  endfunction

  // First level is floor(log2), second level splits that octave in four.
  function automatic int unsigned bin_index(int unsigned sz);
    int unsigned fl;
    int unsigned sl;
    int unsigned v;
    int unsigned base;
    int unsigned step;
    fl = 0;
    v = sz;
    while (v > 1) begin
      v = v >> 1;
      fl++;
    end
    if (fl > 23) fl = 23;
    base = 1 << fl;
    step = base / 4;
    if (step == 0) step = 1;
    sl = ((sz > base) ? sz - base : 0) / step;
    if (sl > 3) sl = 3;
    return fl * 4 + sl;
  endfunction

  function automatic void take_from_bin(int unsigned b);
    int unsigned bn;
    int unsigned nx;
    int unsigned pv;
    bn = bin_index(size_at(b));
    nx = mem_rd(b + 8);
    pv = mem_rd(b + 12);
    if (pv != NONE) mem_wr(pv + 8, nx);
    else if (bn < BINS) free_heads[bn] = nx & NONE;
    if (nx != NONE) mem_wr(nx + 12, pv);
    mem_wr(b + 8, NONE);
    mem_wr(b + 12, NONE);
  endfunction

  function automatic void put_in_bin(int unsigned b);
    int unsigned bn;
    int unsigned nx;
    bn = bin_index(size_at(b));
    if (bn >= BINS) return;
    nx = free_heads[bn];
    mem_wr(b + 12, NONE);
    mem_wr(b + 8, nx);
    if (nx != NONE) mem_wr(nx + 12, b);
    free_heads[bn] = b & NONE;
  endfunction

  function automatic int unsigned first_fit(int unsigned needed);
    int unsigned b;
    int unsigned guard;
    for (int unsigned k = bin_index(needed); k < BINS; k++) begin
      b = free_heads[k];
      guard = 0;
      while (b != NONE && guard <= MEM_WORDS) begin
        if (size_at(b) >= needed) return b;
        b = mem_rd(b + 8);
        guard++;
      end
    end
    return NONE;
  endfunction

  function automatic void model_format();
    int unsigned total;
    int unsigned avail;
    foreach (free_heads[k]) free_heads[k] = NONE;
    pool_up = 1'b0;
    pool_end = 0;
    total = pool_size_reg;
    if (total > 65536) total = 65536;
    if (total <= 32) return;
    avail = total & ~32'd7;
    mem_wr(0, avail - 8);
    mem_wr(4, 0);
    mem_wr(avail - 8, 1);
    mem_wr(avail - 4, avail - 8);
    pool_end = avail;
    pool_up = 1'b1;
    put_in_bin(0);
  endfunction

  // A pointer is good only if walking the block chain lands on a used block.
  function automatic bit is_live_block(int unsigned b);
    int unsigned c;
    int unsigned s;
    if (!pool_up || b >= pool_end) return 1'b0;
    c = 0;
    while (c < b) begin
      s = size_at(c);
      if (s == 0) return 1'b0;
      c += s;
    end
    return c == b && size_at(b) != 0 && used_at(b);
  endfunction

  function automatic logic [1:0] model_alloc(longint unsigned sz, output int unsigned addr);
    longint unsigned need;
    int unsigned needed;
    int unsigned b;
    int unsigned rest;
    int unsigned sp;
    int unsigned s;
    addr = 0;
    if (sz == 0) return STATUS_REJECT;
    if (!pool_up) return STATUS_NO_SPACE;
    need = (sz + 15) & ~64'd7;
    if (need < 24) need = 24;
    if (need > pool_end) return STATUS_NO_SPACE;
    needed = 32'(need);
    b = first_fit(needed);
    if (b == NONE) return STATUS_NO_SPACE;
    take_from_bin(b);
    rest = size_at(b) - needed;
    if (rest >= 24) begin
      sp = b + needed;
      mem_wr(sp, rest);
      mem_wr(sp + 4, needed);
      mem_wr(b, needed | 1);
      mem_wr(sp + rest + 4, rest);
      put_in_bin(sp);
    end else begin
      s = size_at(b);
      mem_wr(b, s | 1);
      mem_wr(b + s + 4, s);
    end
    addr = (b + 8) & 16'hFFFF;
    return STATUS_OK;
  endfunction

  // Frees a known-good block and merges it with free neighbours.
  function automatic void model_release(int unsigned b);
    int unsigned s;
    int unsigned f;
    int unsigned ps;
    int unsigned p;
    s = size_at(b);
    mem_wr(b, s);
    f = b + s;
    if (size_at(f) != 0 && !used_at(f)) begin
      take_from_bin(f);
      s += size_at(f);
      mem_wr(b, s);
      mem_wr(b + s + 4, s);
    end
    ps = mem_rd(b + 4);
    if (ps != 0 && ps <= b) begin
      p = b - ps;
      if (!used_at(p)) begin
        take_from_bin(p);
        s += size_at(p);
        mem_wr(p, s);
        mem_wr(p + s + 4, s);
        b = p;
      end
    end
    put_in_bin(b);
  endfunction

  function automatic outcome_t predict_request(logic [1:0] cmd, logic [31:0] sz,
                                               logic [15:0] ptr);
    outcome_t r;
    int unsigned a;
    int unsigned b;
    int unsigned old;
    r = '{addr: 16'd0, stat: STATUS_REJECT, copy: 17'd0};
    a = 0;
    b = ptr - 8;
    if (cmd == CMD_ALLOC) begin
      r.stat = model_alloc(sz, a);
    end else if (cmd == CMD_FREE) begin
      if (ptr >= 8 && is_live_block(b)) begin
        model_release(b);
        r.stat = STATUS_OK;
      end
    end else if (cmd == CMD_RESIZE) begin
      if (ptr == 0) begin
        r.stat = model_alloc(sz, a);
      end else if (ptr >= 8 && is_live_block(b)) begin
        old = size_at(b) - 8;
        if (sz == 0) begin
          model_release(b);
          r.stat = STATUS_FREED;
        end else if (sz <= old) begin
          a = ptr;
          r.stat = STATUS_OK;
        end else begin
          r.stat = model_alloc(sz, a);
          if (r.stat == STATUS_OK) begin
            r.copy = 17'(old);
            model_release(b);
          end
        end
      end
    end
    r.addr = 16'(a);
    return r;
  endfunction

  // Keeps the list of payload offsets the bench believes are allocated.
  function automatic void note_live(logic [1:0] cmd, logic [15:0] ptr, outcome_t r);
    bit dropped;
    dropped = (cmd == CMD_FREE && r.stat == STATUS_OK) || r.stat == STATUS_FREED ||
              (cmd == CMD_RESIZE && ptr != 0 && r.stat == STATUS_OK && r.addr != ptr);
    if (dropped) begin
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == ptr) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
    if (r.stat == STATUS_OK && r.addr != 0 && (cmd == CMD_ALLOC || r.addr != ptr))
      live_blocks.push_back(r.addr);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done beat is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: addr %0d status %0d copy %0d",
                 $time, result_address, status, copy_bytes);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_address !== want.addr) begin
          $display("%0t: result_address expected %0d actual %0d",
                   $time, want.addr, result_address);
          mismatches++;
        end
        if (status !== want.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, want.stat, status);
          mismatches++;
        end
        if (copy_bytes !== want.copy) begin
          $display("%0t: copy_bytes expected %0d actual %0d", $time, want.copy, copy_bytes);
          mismatches++;
        end
      end
    end
  end

  // The run ends as a failure if it takes far longer than the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Drives one request beat and waits until the block takes it. The caller
  // sits at a rising edge; start is left high so a following beat can go
  // back to back, and lowered only by hold_start or drain.
  task automatic send_request(logic [1:0] cmd, logic [31:0] sz, logic [15:0] ptr);
    outcome_t r;
    if (!no_gaps && $urandom_range(99) < 20) hold_start($urandom_range(6, 1));
    start <= 1'b1;
    command <= cmd;
    request_size <= sz;
    block_address <= ptr;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_request(cmd, sz, ptr);
    pending_results.push_back(r);
    note_live(cmd, ptr, r);
  endtask

  task automatic hold_start(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Pauses the sender until every expected beat is back, plus a margin for
  // the block to settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool_size(logic [16:0] v);
    drain();
    pool_bytes_we <= 1'b1;
    pool_bytes <= v;
    @(posedge clk);
    pool_bytes_we <= 1'b0;
    pool_size_reg = v;
    model_format();
    live_blocks.delete();
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_live();
    if (live_blocks.size() == 0) return 16'd0;
    return live_blocks[$urandom_range(live_blocks.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(200, 1);
    if (roll < 90) return $urandom_range(2000, 1);
    if (roll < 96) return $urandom_range(20000, 1);
    if (roll < 98) return $urandom;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Edge cases on the full pool: zero and oversized requests, bad and null
  // pointers, the unused command, and the resize paths but a pointer below 8.
  task automatic test_directed();
    logic [15:0] a;
    logic [15:0] b;
    send_request(CMD_ALLOC, 32'd0, 16'd0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_ALLOC, 32'd65536, 16'd0);
    send_request(CMD_FREE, 32'd0, 16'd0);
    send_request(CMD_RESIZE, 32'd5, 16'hFFFF);
    send_request(CMD_UNUSED, 32'd16, 16'd8);
    send_request(CMD_ALLOC, 32'd1, 16'd0);
    a = pick_live();
    send_request(CMD_ALLOC, 32'd100, 16'd0);
    b = live_blocks[live_blocks.size() - 1];
    send_request(CMD_FREE, 32'd0, 16'd4);
    send_request(CMD_FREE, 32'd0, a + 16'd1);
    send_request(CMD_RESIZE, 32'd16, a);
    send_request(CMD_RESIZE, 32'd300, a);
    send_request(CMD_RESIZE, 32'hFFFF_FFFF, b);
    send_request(CMD_RESIZE, 32'd0, b);
    send_request(CMD_FREE, 32'd0, b);
    send_request(CMD_RESIZE, 32'd40, 16'd0);
    send_request(CMD_ALLOC, 32'd65520, 16'd0);
    drain();
  endtask

  // Register settings: too small to format, the largest size that still stays unformatted,
  // the smallest usable pool, a value above the address span, and an odd size.
  task automatic test_pool_sizes();
    write_pool_size(17'd0);
    send_request(CMD_ALLOC, 32'd8, 16'd0);
    send_request(CMD_FREE, 32'd0, 16'd8);
    send_request(CMD_RESIZE, 32'd8, 16'd8);
    send_request(CMD_RESIZE, 32'd8, 16'd0);
    write_pool_size(17'd32);
    send_request(CMD_ALLOC, 32'd1, 16'd0);
    write_pool_size(17'd33);
    send_request(CMD_ALLOC, 32'd17, 16'd0);
    send_request(CMD_ALLOC, 32'd16, 16'd0);
    send_request(CMD_ALLOC, 32'd1, 16'd0);
    send_request(CMD_FREE, 32'd0, 16'd8);
    send_request(CMD_FREE, 32'd0, 16'd8);
    write_pool_size(17'h1FFFF);
    send_request(CMD_ALLOC, 32'd65528, 16'd0);
    send_request(CMD_ALLOC, 32'd65520, 16'd0);
    write_pool_size(17'd1003);
    repeat (10) send_request(CMD_ALLOC, $urandom_range(120, 1), 16'd0);
    drain();
  endtask

  // Mostly well-formed traffic on live blocks, with noise pointers and sizes.
  task automatic test_random_traffic(int n);
    int unsigned roll;
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= n / 3) && (i < n / 3 + 150);
      roll = $urandom_range(99);
      if (roll < 45)
        send_request(CMD_ALLOC, pick_size(), 16'($urandom));
      else if (roll < 75)
        send_request(CMD_FREE, $urandom, pick_live());
      else if (roll < 90)
        send_request(CMD_RESIZE, pick_size(), pick_live());
      else if (roll < 93)
        send_request(CMD_RESIZE, pick_size(), 16'd0);
      else if (roll < 98)
        send_request(2'($urandom_range(3)), $urandom, 16'($urandom));
      else
        send_request(CMD_UNUSED, $urandom, pick_live());
      if (i == n / 2) drain();
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_ALLOC;
    request_size = 32'd0;
    block_address = 16'd0;
    pool_bytes_we = 1'b0;
    pool_bytes = 17'd0;
    mismatches = 0;
    cycles = 0;
    no_gaps = 1'b0;
    foreach (pool_mem[i]) pool_mem[i] = 32'd0;
    pool_size_reg = 65536;
    model_format();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    test_directed();
    test_pool_sizes();
    write_pool_size(17'd4096);
    test_random_traffic(400);
    write_pool_size(17'd65536);
    test_random_traffic(1000);

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
